// ----- sv/ascii_expression_calculator_top_assert.svh -----
// assertion macros for the ascii expression calculator
// expects a clock named clock and an active high reset named reset in scope
`ifndef ASCII_EXPRESSION_CALCULATOR_TOP_ASSERT_SVH
`define ASCII_EXPRESSION_CALCULATOR_TOP_ASSERT_SVH

// same-cycle implication
`define AEC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AEC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/aec_pkg.sv -----
// shared types, constants and helper functions of the ascii expression calculator
// no dependencies
package aec_pkg;

   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_BANG  = 8'h21;
   localparam logic [7:0] CHR_STAR  = 8'h2A;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ERROR = 2'd1;
   localparam logic [1:0] ST_INF   = 2'd2;

   localparam logic signed [31:0] FACT_MAX   = 32'sd12;
   localparam logic signed [63:0] PROD_LIMIT = 64'sd1000000;
   localparam logic signed [35:0] ACC_MAX    = 36'sh07FFFFFFF;
   localparam logic signed [35:0] ACC_MIN    = -36'sh080000000;

   typedef struct packed {
      logic start_first;
      logic start_second;
      logic acc_first;
      logic acc_second;
      logic set_op;
      logic fin_fact;
      logic fin_add;
      logic fin_sub;
      logic mul_load;
      logic fin_mul;
      logic div_start;
      logic fin_div;
      logic fin_err;
      logic fin_inf;
      logic emit;
   } aec_cmd_type;

   typedef struct packed {
      logic op_plus;
      logic op_minus;
      logic op_mul;
      logic op_div;
      logic second_zero;
      logic div_done;
   } aec_stat_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHR_ZERO) && (c <= CHR_NINE);
   endfunction

   // v * 10 +/- digit, saturated to 32 bits
   function automatic logic signed [31:0] accumulate(input logic signed [31:0] v,
                                                     input logic neg,
                                                     input logic [7:0] c);
      logic signed [35:0] t;
      logic signed [35:0] d;
      t = (36'(v) <<< 3) + (36'(v) <<< 1);
      d = 36'(c[3:0]);
      if (neg) begin
         t = t - d;
      end else begin
         t = t + d;
      end
      if (t > ACC_MAX) begin
         return 32'sh7FFFFFFF;
      end else if (t < ACC_MIN) begin
         return 32'sh80000000;
      end
      return t[31:0];
   endfunction

   function automatic logic [31:0] fact_value(input logic [3:0] n);
      logic [31:0] f;
      case (n)
         4'd0:    f = 32'd1;
         4'd1:    f = 32'd1;
         4'd2:    f = 32'd2;
         4'd3:    f = 32'd6;
         4'd4:    f = 32'd24;
         4'd5:    f = 32'd120;
         4'd6:    f = 32'd720;
         4'd7:    f = 32'd5040;
         4'd8:    f = 32'd40320;
         4'd9:    f = 32'd362880;
         4'd10:   f = 32'd3628800;
         4'd11:   f = 32'd39916800;
         4'd12:   f = 32'd479001600;
         default: f = 32'd0;
      endcase
      return f;
   endfunction

endpackage

// ----- sv/aec_div.sv -----
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on nothing
module aec_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? (~dividend + 32'd1) : dividend;
         dvs_in  = divisor[31] ? (~divisor + 32'd1) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // magnitude 2^31 with positive sign wraps to the most negative value
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 32'd1) : quo_ff;

endmodule

// ----- sv/aec_datapath.sv -----
// operand registers, digit accumulation, result arithmetic and result word register
// depends on aec_pkg and aec_div
module aec_datapath (
   input  logic               clock,
   input  logic               reset,
   input  aec_pkg::aec_cmd_type cmd,
   input  logic [7:0]         char_byte,
   output aec_pkg::aec_stat_type stat,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value
);
   import aec_pkg::*;

   logic signed [31:0] first_ff, first_in;
   logic signed [31:0] second_ff, second_in;
   logic               neg_ff, neg_in;
   logic [7:0]         op_ff, op_in;
   logic [1:0]         est_ff, est_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               div_done;
   logic signed [31:0] div_quo;
   logic               char_minus;

   aec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (first_ff),
      .divisor  (second_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign char_minus = (char_byte == CHR_MINUS);
   assign prod_in    = first_ff * second_ff;

   always_comb begin
      first_in      = first_ff;
      second_in     = second_ff;
      neg_in        = neg_ff;
      op_in         = op_ff;
      est_in        = est_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (cmd.start_first) begin
         neg_in   = char_minus;
         first_in = char_minus ? 32'sd0 : 32'(char_byte[3:0]);
      end
      if (cmd.start_second) begin
         neg_in    = char_minus;
         second_in = char_minus ? 32'sd0 : 32'(char_byte[3:0]);
      end
      if (cmd.acc_first) begin
         first_in = accumulate(first_ff, neg_ff, char_byte);
      end
      if (cmd.acc_second) begin
         second_in = accumulate(second_ff, neg_ff, char_byte);
      end
      if (cmd.set_op) begin
         op_in = char_byte;
      end
      if (cmd.fin_fact) begin
         if (first_ff > FACT_MAX) begin
            est_in   = ST_INF;
            first_in = '0;
         end else if (first_ff[31]) begin
            est_in   = ST_ERROR;
            first_in = '0;
         end else begin
            est_in   = ST_OK;
            first_in = fact_value(first_ff[3:0]);
         end
      end
      if (cmd.fin_add) begin
         est_in   = ST_OK;
         first_in = first_ff + second_ff;
      end
      if (cmd.fin_sub) begin
         est_in   = ST_OK;
         first_in = first_ff - second_ff;
      end
      if (cmd.fin_mul) begin
         // range check on the full product
         if (prod_ff <= PROD_LIMIT && prod_ff >= -PROD_LIMIT) begin
            est_in   = ST_OK;
            first_in = prod_ff[31:0];
         end else begin
            est_in   = ST_INF;
            first_in = '0;
         end
      end
      if (cmd.fin_div) begin
         est_in   = ST_OK;
         first_in = div_quo;
      end
      if (cmd.fin_err) begin
         est_in   = ST_ERROR;
         first_in = '0;
      end
      if (cmd.fin_inf) begin
         est_in   = ST_INF;
         first_in = '0;
      end
      if (cmd.emit) begin
         rsp_status_in = est_ff;
         rsp_value_in  = (est_ff == ST_OK) ? first_ff : 32'sd0;
         first_in      = '0;
         second_in     = '0;
         neg_in        = 1'b0;
         op_in         = CHR_NUL;
         est_in        = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         neg_ff    <= 1'b0;
         op_ff     <= CHR_NUL;
         est_ff    <= ST_OK;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         neg_ff    <= neg_in;
         op_ff     <= op_in;
         est_ff    <= est_in;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign stat.op_plus     = (op_ff == CHR_PLUS);
   assign stat.op_minus    = (op_ff == CHR_MINUS);
   assign stat.op_mul      = (op_ff == CHR_STAR);
   assign stat.op_div      = (op_ff == CHR_SLASH);
   assign stat.second_zero = (second_ff == 32'sd0);
   assign stat.div_done    = div_done;

   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

// ----- sv/aec_ctrl.sv -----
// parse state machine: walks the grammar, issues datapath commands, owns the result valid
// depends on aec_pkg and the assertion macro header
`include "ascii_expression_calculator_top_assert.svh"

module aec_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  aec_pkg::aec_stat_type stat,
   output aec_pkg::aec_cmd_type  cmd
);
   import aec_pkg::*;

   typedef enum logic [10:0] {
      S_START  = 11'b00000000001,
      S_BANG   = 11'b00000000010,
      S_FIRST  = 11'b00000000100,
      S_PRE_OP = 11'b00000001000,
      S_POST_OP = 11'b00000010000,
      S_SECOND = 11'b00000100000,
      S_DONE   = 11'b00001000000,
      S_MUL    = 11'b00010000000,
      S_DIV    = 11'b00100000000,
      S_EMIT   = 11'b01000000000,
      S_IDLE_X = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      fact_ff, fact_in;
   logic      term_ff, term_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      c_nul;
   logic      c_space;
   logic      c_digit;
   logic      c_num;
   logic      do_binary;
   logic      bin_term;
   state_type after_bin;

   assign req_ready = !reset &&
                      ((state_ff == S_START) || (state_ff == S_BANG) ||
                       (state_ff == S_FIRST) || (state_ff == S_PRE_OP) ||
                       (state_ff == S_POST_OP) || (state_ff == S_SECOND) ||
                       (state_ff == S_DONE));
   assign accept  = req_valid && req_ready;
   assign c_nul   = (req_char_byte == CHR_NUL);
   assign c_space = is_space(req_char_byte);
   assign c_digit = is_digit(req_char_byte);
   assign c_num   = c_digit || (req_char_byte == CHR_MINUS);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      fact_in      = fact_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff;
      do_binary    = 1'b0;
      bin_term     = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_START: begin
            if (accept) begin
               if (c_nul) begin
                  cmd.fin_err = 1'b1;
                  state_in    = S_EMIT;
               end else if (c_space) begin
                  state_in = S_START;
               end else if (req_char_byte == CHR_BANG) begin
                  fact_in  = 1'b1;
                  state_in = S_BANG;
               end else if (c_num) begin
                  cmd.start_first = 1'b1;
                  state_in        = S_FIRST;
               end else begin
                  cmd.fin_err = 1'b1;
                  state_in    = S_DONE;
               end
            end
         end
         S_BANG: begin
            if (accept) begin
               if (c_nul) begin
                  cmd.fin_err = 1'b1;
                  state_in    = S_EMIT;
               end else if (c_space) begin
                  state_in = S_BANG;
               end else if (c_num) begin
                  cmd.start_first = 1'b1;
                  state_in        = S_FIRST;
               end else begin
                  cmd.fin_err = 1'b1;
                  state_in    = S_DONE;
               end
            end
         end
         S_FIRST: begin
            if (accept) begin
               if (c_nul) begin
                  cmd.fin_fact = fact_ff;
                  cmd.fin_err  = !fact_ff;
                  state_in     = S_EMIT;
               end else if (c_digit) begin
                  cmd.acc_first = 1'b1;
               end else if (fact_ff) begin
                  // anything after the factorial operand is ignored
                  cmd.fin_fact = 1'b1;
                  state_in     = S_DONE;
               end else if (c_space) begin
                  state_in = S_PRE_OP;
               end else begin
                  cmd.set_op = 1'b1;
                  state_in   = S_POST_OP;
               end
            end
         end
         S_PRE_OP: begin
            if (accept) begin
               if (c_nul) begin
                  cmd.fin_err = 1'b1;
                  state_in    = S_EMIT;
               end else if (!c_space) begin
                  cmd.set_op = 1'b1;
                  state_in   = S_POST_OP;
               end
            end
         end
         S_POST_OP: begin
            if (accept) begin
               if (c_nul) begin
                  cmd.fin_err = 1'b1;
                  state_in    = S_EMIT;
               end else if (c_space) begin
                  state_in = S_POST_OP;
               end else if (c_num) begin
                  cmd.start_second = 1'b1;
                  state_in         = S_SECOND;
               end else begin
                  cmd.fin_err = 1'b1;
                  state_in    = S_DONE;
               end
            end
         end
         S_SECOND: begin
            if (accept) begin
               if (c_nul) begin
                  do_binary = 1'b1;
                  bin_term  = 1'b1;
               end else if (c_digit) begin
                  cmd.acc_second = 1'b1;
               end else begin
                  do_binary = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (accept && c_nul) begin
               state_in = S_EMIT;
            end
         end
         S_MUL: begin
            cmd.fin_mul = 1'b1;
            state_in    = term_ff ? S_EMIT : S_DONE;
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.fin_div = 1'b1;
               state_in    = term_ff ? S_EMIT : S_DONE;
            end
         end
         S_EMIT: begin
            // load the result word once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               fact_in      = 1'b0;
               state_in     = S_START;
            end
         end
         default: begin
            state_in = S_START;
         end
      endcase

      after_bin = bin_term ? S_EMIT : S_DONE;
      if (do_binary) begin
         term_in = bin_term;
         if (stat.op_plus) begin
            cmd.fin_add = 1'b1;
            state_in    = after_bin;
         end else if (stat.op_minus) begin
            cmd.fin_sub = 1'b1;
            state_in    = after_bin;
         end else if (stat.op_mul) begin
            cmd.mul_load = 1'b1;
            state_in     = S_MUL;
         end else if (stat.op_div) begin
            if (stat.second_zero) begin
               cmd.fin_inf = 1'b1;
               state_in    = after_bin;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end else begin
            cmd.fin_err = 1'b1;
            state_in    = after_bin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_START;
         fact_ff      <= 1'b0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fact_ff      <= fact_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `AEC_ASSERT_IMP(a_div_nonzero, cmd.div_start, !stat.second_zero, "divider started on zero")
   `AEC_ASSERT_NXT(a_div_wait, cmd.div_start, state_ff == S_DIV, "divider start without wait")
   `AEC_ASSERT_NXT(a_emit_valid, cmd.emit, rsp_valid_ff && state_ff == S_START, "emit lost word")
   `AEC_ASSERT_NXT(a_nul_path, accept && c_nul, state_ff == S_EMIT || state_ff == S_MUL || state_ff == S_DIV, "terminator not routed to result")
   `AEC_ASSERT_NXT(a_emit_hold, state_ff == S_EMIT && rsp_valid_ff && !rsp_ready, state_ff == S_EMIT, "result overwritten")

endmodule

// ----- sv/ascii_expression_calculator_top.sv -----
// ascii expression calculator: characters in, one status/value word per expression out
// depends on aec_pkg, aec_ctrl, aec_datapath (and aec_div below it)
//
// usage:
//   req channel takes one character word per handshake (req_valid/req_ready);
//   a zero byte ends the expression. grammar: '!' then a number, or number, operator, number.
//   rsp channel gives one word (rsp_status, rsp_value) per terminator, none otherwise.
// timing:
//   a non-terminator character is taken when offered, except that a non-digit that ends
//   the second number of a product or a quotient stalls the input in S_MUL or S_DIV, the
//   latter until the one-bit-per-cycle divider is done. a terminator goes through S_EMIT
//   to the result register, after S_MUL for a product and after S_DIV for a quotient.
//   the result sits in an output register; characters of the next expression are
//   taken while it waits; the next terminator is taken too, but then the input
//   stalls until the waiting word has been taken.
// reset: synchronous active high, clears the parse state and the result valid;
//   the block is not ready while reset is high and is ready on the first cycle after.
module ascii_expression_calculator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value
);
   import aec_pkg::*;

   aec_cmd_type  cmd;
   aec_stat_type stat;

   aec_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   aec_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .char_byte  (req_char_byte),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value)
   );

endmodule

// ----- dv/testbench.sv -----
// self-checking bench for ascii_expression_calculator_top: directed and random expressions
// go in one character word at a time and every result word is checked against a predictor
// depends on aec_pkg and the calculator rtl
module testbench;
   import aec_pkg::*;

   typedef enum logic [3:0] {
      P_START, P_AFTER_BANG, P_FIRST_NUM, P_BEFORE_OP, P_AFTER_OP, P_SECOND_NUM, P_DONE
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_char_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_value;

   logic [7:0] char_queue[$];
   answer_type pending_answers[$];
   int         chars_taken = 0;
   int         mismatches = 0;
   int         ok_seen = 0;
   int         err_seen = 0;
   int         inf_seen = 0;
   int         send_idle_pct;
   int         recv_stall_pct;

   // parser shadow state
   parse_phase_type    parse_phase;
   logic               fact_mode;
   logic signed [31:0] lhs;
   logic signed [31:0] rhs;
   logic               minus_seen;
   logic [7:0]         op_char;
   logic [1:0]         held_status;

   ascii_expression_calculator_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_byte(req_char_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_value(rsp_value)
   );

   always #5 clock = ~clock;

   function automatic logic char_is_blank(input logic [7:0] c);
      return c == CHR_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic char_is_numeral(input logic [7:0] c);
      return c >= CHR_ZERO && c <= CHR_NINE;
   endfunction

   // next decimal digit, clamped to the 32-bit signed range
   function automatic logic signed [31:0] push_digit(input logic signed [31:0] v,
                                                     input logic neg, input logic [7:0] c);
      longint t;
      longint d;
      d = c - CHR_ZERO;
      t = longint'(v) * 10;
      t = neg ? t - d : t + d;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
   endfunction

   task automatic clear_parser();
      parse_phase = P_START;
      fact_mode   = 1'b0;
      lhs         = '0;
      rhs         = '0;
      minus_seen  = 1'b0;
      op_char     = '0;
      held_status = ST_OK;
   endtask

   task automatic settle(input logic [1:0] st, input logic signed [31:0] v);
      held_status = st;
      lhs         = (st == ST_OK) ? v : '0;
      parse_phase = P_DONE;
   endtask

   task automatic settle_factorial();
      int f;
      f = 1;
      if (lhs > FACT_MAX) begin
         settle(ST_INF, '0);
      end else if (lhs < 0) begin
         settle(ST_ERROR, '0);
      end else begin
         for (int k = 2; k <= lhs; k++) f = f * k;
         settle(ST_OK, f);
      end
   endtask

   task automatic settle_binary();
      longint p;
      case (op_char)
         CHR_PLUS:  settle(ST_OK, lhs + rhs);
         CHR_MINUS: settle(ST_OK, lhs - rhs);
         CHR_STAR: begin
            p = longint'(lhs) * longint'(rhs);
            if (p > PROD_LIMIT || p < -PROD_LIMIT) settle(ST_INF, '0);
            else settle(ST_OK, p[31:0]);
         end
         CHR_SLASH: begin
            if (rhs == 0) begin
               settle(ST_INF, '0);
            end else begin
               p = longint'(lhs) / longint'(rhs);
               settle(ST_OK, p[31:0]);
            end
         end
         default: settle(ST_ERROR, '0);
      endcase
   endtask

   task automatic open_number(input logic [7:0] c, output logic signed [31:0] v);
      minus_seen = (c == CHR_MINUS);
      v = minus_seen ? 32'sd0 : 32'(c - CHR_ZERO);
   endtask

   // advance the shadow parser by one character; a terminator queues one answer
   task automatic eval_char(input logic [7:0] c);
      answer_type w;
      if (c == CHR_NUL) begin
         if (parse_phase == P_FIRST_NUM && fact_mode) settle_factorial();
         else if (parse_phase == P_SECOND_NUM) settle_binary();
         else if (parse_phase != P_DONE) settle(ST_ERROR, '0);
         w.status = held_status;
         w.value  = (held_status == ST_OK) ? lhs : '0;
         pending_answers.push_back(w);
         clear_parser();
      end else begin
         case (parse_phase)
            P_START: begin
               if (char_is_blank(c)) begin
               end else if (c == CHR_BANG) begin
                  fact_mode   = 1'b1;
                  parse_phase = P_AFTER_BANG;
               end else if (char_is_numeral(c) || c == CHR_MINUS) begin
                  open_number(c, lhs);
                  parse_phase = P_FIRST_NUM;
               end else begin
                  settle(ST_ERROR, '0);
               end
            end
            P_AFTER_BANG: begin
               if (char_is_blank(c)) begin
               end else if (char_is_numeral(c) || c == CHR_MINUS) begin
                  open_number(c, lhs);
                  parse_phase = P_FIRST_NUM;
               end else begin
                  settle(ST_ERROR, '0);
               end
            end
            P_FIRST_NUM: begin
               if (char_is_numeral(c)) begin
                  lhs = push_digit(lhs, minus_seen, c);
               end else if (fact_mode) begin
                  settle_factorial();
               end else if (char_is_blank(c)) begin
                  parse_phase = P_BEFORE_OP;
               end else begin
                  op_char     = c;
                  parse_phase = P_AFTER_OP;
               end
            end
            P_BEFORE_OP: begin
               if (!char_is_blank(c)) begin
                  op_char     = c;
                  parse_phase = P_AFTER_OP;
               end
            end
            P_AFTER_OP: begin
               if (char_is_blank(c)) begin
               end else if (char_is_numeral(c) || c == CHR_MINUS) begin
                  open_number(c, rhs);
                  parse_phase = P_SECOND_NUM;
               end else begin
                  settle(ST_ERROR, '0);
               end
            end
            P_SECOND_NUM: begin
               if (char_is_numeral(c)) rhs = push_digit(rhs, minus_seen, c);
               else settle_binary();
            end
            default: begin
            end
         endcase
      end
   endtask

   // ---------------- stimulus building ----------------

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
   endtask

   task automatic add_expr(input string s);
      add_text(s);
      char_queue.push_back(CHR_NUL);
   endtask

   task automatic add_blanks();
      int n;
      n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 2);
      for (int i = 0; i < n; i++)
         char_queue.push_back(($urandom_range(2) == 0) ? CHR_SPACE : 8'($urandom_range(9, 13)));
   endtask

   task automatic add_number();
      int v;
      int n;
      case ($urandom_range(9))
         0, 1, 2: add_text($sformatf("%0d", $urandom_range(0, 20)));
         3:       add_text($sformatf("-%0d", $urandom_range(0, 20)));
         4, 5:    begin
            v = int'($urandom());
            add_text($sformatf("%0d", v));
         end
         6:       add_text($sformatf("%0d", int'($urandom_range(0, 99999)) - 50000));
         7:       begin
            // long digit runs can drive the accumulator into saturation
            if ($urandom_range(1)) char_queue.push_back(CHR_MINUS);
            n = $urandom_range(10, 13);
            char_queue.push_back(8'($urandom_range(8'h31, 8'h39)));
            for (int i = 1; i < n; i++) char_queue.push_back(8'($urandom_range(8'h30, 8'h39)));
         end
         8:       char_queue.push_back(CHR_MINUS);
         default: add_text("0");
      endcase
   endtask

   task automatic add_operator();
      case ($urandom_range(10))
         0, 1, 2: char_queue.push_back(CHR_PLUS);
         3, 4:    char_queue.push_back(CHR_MINUS);
         5, 6:    char_queue.push_back(CHR_STAR);
         7, 8:    char_queue.push_back(CHR_SLASH);
         default: char_queue.push_back(8'($urandom_range(1, 255)));
      endcase
   endtask

   task automatic add_trailer();
      int n;
      if ($urandom_range(1)) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) char_queue.push_back(8'($urandom_range(1, 255)));
      end
   endtask

   task automatic add_binary_body();
      add_blanks();
      add_number();
      add_blanks();
      add_operator();
      add_blanks();
      add_number();
      add_trailer();
   endtask

   task automatic add_random_expr();
      int pick;
      int a;
      int b;
      int mark;
      int cut;
      pick = $urandom_range(99);
      if (pick < 58) begin
         add_binary_body();
      end else if (pick < 73) begin
         add_blanks();
         char_queue.push_back(CHR_BANG);
         add_blanks();
         add_text($sformatf("%0d", int'($urandom_range(0, 18)) - 3));
         add_trailer();
      end else if (pick < 83) begin
         // products around the +/-1000000 limit
         a = $urandom_range(1, 2000);
         b = 1000000 / a + int'($urandom_range(0, 2)) - 1;
         if ($urandom_range(1)) a = -a;
         if ($urandom_range(1)) b = -b;
         add_text($sformatf("%0d*%0d", a, b));
      end else if (pick < 94) begin
         // well-formed start, cut short
         mark = char_queue.size();
         add_binary_body();
         cut = $urandom_range(0, char_queue.size() - mark - 1);
         while (char_queue.size() > mark + cut) void'(char_queue.pop_back());
      end else begin
         a = $urandom_range(1, 8);
         for (int i = 0; i < a; i++) char_queue.push_back(8'($urandom_range(1, 255)));
      end
      char_queue.push_back(CHR_NUL);
   endtask

   task automatic add_directed();
      add_expr("12+30");
      add_expr(" \011-7 - 9");
      add_expr("6*-7");
      add_expr("1000*1000");
      add_expr("1000*1001");
      add_expr("-1000001 * 1");
      add_expr("-17/5");
      add_expr("5/0");
      add_expr("-2147483648/-1");
      add_expr("2147483647+1");
      add_expr("99999999999-1");
      add_expr("-99999999999+0");
      add_expr("!12");
      add_expr("!13");
      add_expr("!-3");
      add_expr("! 4+9");
      add_expr("!!3");
      add_expr("-+5");
      add_expr("");
      add_expr("7 ");
      add_expr("7+x");
      add_expr("7%3");
      add_expr("\015\012\013\0141\014*\015 2");
      add_expr("8/2 junk");
      char_queue.push_back(8'h80);
      char_queue.push_back(CHR_NUL);
      add_text("3");
      char_queue.push_back(8'hFF);
      add_expr("4");
   endtask

   // ---------------- driver ----------------

   // idling stretches: none, sender idle, receiver stalling, both
   always_comb begin
      case ((chars_taken / 120) % 4)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
         default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_char_byte <= 8'd0;
         clear_parser();
      end else begin
         if (req_valid && req_ready) begin
            eval_char(req_char_byte);
            chars_taken <= chars_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_char_byte <= char_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin : result_check
      answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            case (rsp_status)
               ST_OK:    ok_seen++;
               ST_ERROR: err_seen++;
               default:  inf_seen++;
            endcase
            if (pending_answers.size() == 0) begin
               $error("result word with none pending: status %0d value %0d",
                      rsp_status, rsp_value);
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_value);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------- sequence ----------------

   initial begin
      add_directed();
      while (char_queue.size() < 750) add_random_expr();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (char_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      // slowest path is a quotient, which waits on the iterative divider
      repeat (60) @(posedge clock);
      $display("sent %0d characters, checked %0d result words", chars_taken,
               ok_seen + err_seen + inf_seen);
      $display("statuses seen: %0d ok, %0d error, %0d infinite", ok_seen, err_seen, inf_seen);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d results outstanding", pending_answers.size());
      $display("FAILURE");
      $finish;
   end

endmodule
